// ===== rtl/core/ctd_pkg.sv =====
// types, codes and character constants for the chunked transfer decoder
// used by chunked_transfer_decoder; no dependencies
`default_nettype none

package ctd_pkg;

    localparam int TotalW = 25;
    localparam logic [TotalW-1:0] MAX_TOTAL_RESET = 25'd8388608;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    typedef enum logic [0:0] {
        ACT_BYTE = 1'b0,
        ACT_END  = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        PH_SIZE    = 4'd0,
        PH_SIZE_CR = 4'd1,
        PH_EXT     = 4'd2,
        PH_EXT_CR  = 4'd3,
        PH_DATA    = 4'd4,
        PH_DATA_CR = 4'd5,
        PH_DATA_LF = 4'd6,
        PH_DONE    = 4'd7,
        PH_ERROR   = 4'd8
    } phase_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
    } out_item_t;

    // {valid, value} for an ascii hex digit of either case
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        case (c) inside
            [8'h30:8'h39]: res = {1'b1, 4'(c - 8'h30)};
            [8'h61:8'h66]: res = {1'b1, 4'(c - 8'h57)};
            [8'h41:8'h46]: res = {1'b1, 4'(c - 8'h37)};
            default:       res = 5'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/chunked_transfer_decoder.sv =====
// chunked transfer decoder top level: byte-wide http/1.1 chunked body parser
// depends on ctd_pkg
//
// usage
//   s_* channel: one beat per raw body byte (action = byte) or an end beat
//     (action = end) that closes the body and rearms the parser
//   m_* channel: at most one result beat per input beat: a decoded data
//     byte, a body-complete marker, or an error marker
//   cfg_* channel: writes max_total_bytes; always ready, write only while idle
// latency and throughput
//   one input beat per cycle while s_ready holds; its result beat shows up on the
//   cycle after acceptance, straight from the output register
//   the parse state and the size/limit check are combinational logic,
//   the 64-bit size against the 25-bit room left is the longest compare
// stall behavior
//   s_ready drops only while a result beat sits in the output register
//   and m_ready is low; beats that give no result still need s_ready
// reset
//   synchronous active-low aresetn: parser back to expecting a size line,
//   output register empty, max_total_bytes back to 8 MiB
`default_nettype none

module chunked_transfer_decoder
    import ctd_pkg::*;
#(
    parameter int MAX_SIZE_DIGITS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_item_t          s_data,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_item_t              m_data,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [TotalW-1:0] cfg_data
);

    localparam int SizeW = 4 * MAX_SIZE_DIGITS;
    localparam int CntW  = $clog2(MAX_SIZE_DIGITS + 1);
    localparam int CmpW  = (SizeW > TotalW) ? SizeW : TotalW;
    localparam logic [CntW-1:0] DigitLimit = CntW'(MAX_SIZE_DIGITS);

    // parser state
    phase_t              phase_reg, phase_next;
    logic [SizeW-1:0]    size_accum_reg, size_accum_next;
    logic [CntW-1:0]     digit_count_reg, digit_count_next;
    logic [TotalW-1:0]   bytes_left_reg, bytes_left_next;
    logic [TotalW-1:0]   total_out_reg, total_out_next;
    logic [TotalW-1:0]   max_total_reg;

    // output register
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    logic                accept;
    logic                is_end;
    logic [7:0]          c;
    logic [4:0]          hex;
    logic                is_hex, is_cr, is_lf, is_semi;
    logic                size_zero, over_total, size_too_big, line_fail;
    logic [TotalW-1:0]   room;
    phase_t              line_end_phase;
    logic                res_valid;
    out_item_t           res;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // character decode
    assign is_end  = (s_data.action == ACT_END);
    assign c       = s_data.in_byte;
    assign hex     = hex_decode(c);
    assign is_hex  = hex[4];
    assign is_cr   = (c == CHAR_CR);
    assign is_lf   = (c == CHAR_LF);
    assign is_semi = (c == CHAR_SEMI);

    // end of size line: zero size ends the body, else check against the limit
    assign size_zero    = (size_accum_reg == '0);
    assign over_total   = (total_out_reg > max_total_reg);
    assign room         = max_total_reg - total_out_reg;
    assign size_too_big = (CmpW'(size_accum_reg) > CmpW'(room));
    assign line_fail    = over_total || size_too_big;

    always_comb begin
        if (size_zero) begin
            line_end_phase = PH_DONE;
        end else if (line_fail) begin
            line_end_phase = PH_ERROR;
        end else begin
            line_end_phase = PH_DATA;
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            if (is_end) begin
                phase_next = PH_SIZE;
            end else begin
                case (phase_reg)
                    PH_SIZE: begin
                        if (is_hex) begin
                            if (digit_count_reg >= DigitLimit) begin
                                phase_next = PH_ERROR;
                            end
                        end else if (digit_count_reg == '0) begin
                            phase_next = PH_ERROR;
                        end else if (is_semi) begin
                            phase_next = PH_EXT;
                        end else if (is_cr) begin
                            phase_next = PH_SIZE_CR;
                        end else begin
                            phase_next = PH_ERROR;
                        end
                    end
                    PH_SIZE_CR: begin
                        phase_next = is_lf ? line_end_phase : PH_ERROR;
                    end
                    PH_EXT: begin
                        if (is_cr) begin
                            phase_next = PH_EXT_CR;
                        end
                    end
                    PH_EXT_CR: begin
                        // bare crs inside an extension are skipped
                        if (is_lf) begin
                            phase_next = line_end_phase;
                        end else if (!is_cr) begin
                            phase_next = PH_EXT;
                        end
                    end
                    PH_DATA: begin
                        if (bytes_left_reg == TotalW'(1)) begin
                            phase_next = PH_DATA_CR;
                        end
                    end
                    PH_DATA_CR: begin
                        phase_next = is_cr ? PH_DATA_LF : PH_ERROR;
                    end
                    PH_DATA_LF: begin
                        phase_next = is_lf ? PH_SIZE : PH_ERROR;
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // result beat and counters
    always_comb begin
        size_accum_next  = size_accum_reg;
        digit_count_next = digit_count_reg;
        bytes_left_next  = bytes_left_reg;
        total_out_next   = total_out_reg;
        res_valid        = 1'b0;
        res.kind         = KIND_ERROR;
        res.out_byte     = 8'd0;

        if (is_end) begin
            // an open body closed early is an error
            res_valid        = (phase_reg != PH_DONE) && (phase_reg != PH_ERROR);
            size_accum_next  = '0;
            digit_count_next = '0;
            bytes_left_next  = '0;
            total_out_next   = '0;
        end else begin
            if (phase_reg == PH_DATA) begin
                res_valid       = 1'b1;
                res.kind        = KIND_DATA;
                res.out_byte    = c;
                bytes_left_next = bytes_left_reg - TotalW'(1);
                total_out_next  = total_out_reg + TotalW'(1);
            end else if (phase_next == PH_ERROR && phase_reg != PH_ERROR) begin
                res_valid = 1'b1;
                res.kind  = KIND_ERROR;
            end else if (phase_next == PH_DONE && phase_reg != PH_DONE) begin
                res_valid = 1'b1;
                res.kind  = KIND_DONE;
            end

            if (phase_reg == PH_SIZE && is_hex && digit_count_reg < DigitLimit) begin
                size_accum_next  = (size_accum_reg << 4) | SizeW'(hex[3:0]);
                digit_count_next = digit_count_reg + CntW'(1);
            end

            if (phase_next == PH_DATA && phase_reg != PH_DATA) begin
                // size already checked against the room left, fits the counter
                bytes_left_next = TotalW'(size_accum_reg);
            end

            if (phase_reg == PH_DATA_LF && is_lf) begin
                size_accum_next  = '0;
                digit_count_next = '0;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (s_ready) begin
            m_valid_next = s_valid && res_valid;
            m_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_SIZE;
            size_accum_reg  <= '0;
            digit_count_reg <= '0;
            bytes_left_reg  <= '0;
            total_out_reg   <= '0;
            max_total_reg   <= MAX_TOTAL_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            if (accept) begin
                size_accum_reg  <= size_accum_next;
                digit_count_reg <= digit_count_next;
                bytes_left_reg  <= bytes_left_next;
                total_out_reg   <= total_out_next;
            end
            if (cfg_valid && cfg_ready) begin
                max_total_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // a data chunk always has bytes still owed
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> bytes_left_reg != '0)
        else $error("data phase with no bytes left");

    // the digit counter never passes the configured digit limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        digit_count_reg <= DigitLimit)
        else $error("size digit count over limit");

    // a byte taken in the data phase comes out as a data beat next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_end && phase_reg == PH_DATA
        |=> m_valid && m_data.kind == KIND_DATA && m_data.out_byte == $past(c))
        else $error("data byte not passed out");

    // marker beats carry a zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != KIND_DATA |-> m_data.out_byte == 8'd0)
        else $error("marker beat with nonzero byte");

endmodule

`default_nettype wire

// ===== dv/tb_chunked_transfer_decoder.sv =====
// self-checking testbench for chunked_transfer_decoder: directed framing, limit and backpressure cases, then random
// chunked bodies under random input gaps and output backpressure
// depends on ctd_pkg and chunked_transfer_decoder
`timescale 1ns / 100ps

module tb_chunked_transfer_decoder;

    import ctd_pkg::*;

    localparam int ClkPeriod     = 12;
    localparam int MaxSizeDigits = 16;
    localparam int CycleLimit    = 500_000;
    localparam int RandomBeats   = 1300;
    localparam logic [TotalW-1:0] LimitMax = 25'd16777216;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    in_item_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    out_item_t         m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [TotalW-1:0] cfg_data  = '0;

    // parser state tracked beside the block
    phase_t            parse_phase = PH_SIZE;
    logic [63:0]       line_size   = '0;
    logic [4:0]        size_digits = '0;
    logic [63:0]       chunk_left  = '0;
    logic [TotalW-1:0] body_total  = '0;
    logic [TotalW-1:0] body_limit  = MAX_TOTAL_RESET;

    // results the block still owes, oldest first
    out_item_t         decode_due[$];
    out_item_t         oldest_due;
    // beats waiting to be sent
    in_item_t          stim_beats[$];

    // traffic shaping, set by the tests
    int                stall_pct     = 30;
    int                tx_gap_max    = 2;
    int                hold_off_left = 0;
    int                rx_run_left   = 0;
    bit                rx_run_level  = 1'b1;

    int                fail_count    = 0;
    int                cycle_count   = 0;
    int                sent_beats    = 0;
    int                parsed_beats  = 0;
    int                input_stalls  = 0;
    int                data_seen     = 0;
    int                done_seen     = 0;
    int                error_seen    = 0;
    int                limit_phases  = 0;

    chunked_transfer_decoder #(
        .MAX_SIZE_DIGITS(MaxSizeDigits)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #(ClkPeriod / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // decode prediction
    // ------------------------------------------------------------------

    function automatic bit flag_error(output out_item_t res);
        parse_phase  = PH_ERROR;
        res.kind     = KIND_ERROR;
        res.out_byte = 8'h00;
        return 1'b1;
    endfunction

    // size line closed by crlf: zero ends the body, otherwise check the room left
    function automatic bit close_size_line(output out_item_t res);
        res.kind     = KIND_DATA;
        res.out_byte = 8'h00;
        if (line_size == 0) begin
            parse_phase = PH_DONE;
            res.kind    = KIND_DONE;
            return 1'b1;
        end
        // limit lowered under what already went out
        if (body_total > body_limit) return flag_error(res);
        if (line_size > 64'(body_limit - body_total)) return flag_error(res);
        chunk_left  = line_size;
        parse_phase = PH_DATA;
        return 1'b0;
    endfunction

    // one accepted beat in, at most one result out
    function automatic bit decode_beat(input in_item_t beat, output out_item_t res);
        logic [7:0] c;
        logic [3:0] nib;
        bit         digit_ok;
        bit         was_open;
        c            = beat.in_byte;
        nib          = 4'd0;
        res.kind     = KIND_DATA;
        res.out_byte = 8'h00;
        if (beat.action == ACT_END) begin
            // end beat rearms; it only complains about a body left open
            was_open    = parse_phase != PH_DONE && parse_phase != PH_ERROR;
            parse_phase = PH_SIZE;
            line_size   = '0;
            size_digits = '0;
            chunk_left  = '0;
            body_total  = '0;
            res.kind    = KIND_ERROR;
            return was_open;
        end
        case (parse_phase)
            PH_SIZE: begin
                digit_ok = 1'b1;
                if (c >= "0" && c <= "9") nib = 4'(c - "0");
                else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
                else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
                else digit_ok = 1'b0;
                if (digit_ok) begin
                    if (size_digits >= MaxSizeDigits) return flag_error(res);
                    line_size   = {line_size[59:0], nib};
                    size_digits = size_digits + 1'b1;
                    return 1'b0;
                end
                if (size_digits == 0) return flag_error(res);
                if (c == CHAR_SEMI) begin
                    parse_phase = PH_EXT;
                    return 1'b0;
                end
                if (c == CHAR_CR) begin
                    parse_phase = PH_SIZE_CR;
                    return 1'b0;
                end
                return flag_error(res);
            end
            PH_SIZE_CR: begin
                if (c == CHAR_LF) return close_size_line(res);
                return flag_error(res);
            end
            PH_EXT: begin
                if (c == CHAR_CR) parse_phase = PH_EXT_CR;
                return 1'b0;
            end
            PH_EXT_CR: begin
                if (c == CHAR_LF) return close_size_line(res);
                if (c != CHAR_CR) parse_phase = PH_EXT;
                return 1'b0;
            end
            PH_DATA: begin
                chunk_left = chunk_left - 1;
                body_total = body_total + 1'b1;
                if (chunk_left == 0) parse_phase = PH_DATA_CR;
                res.out_byte = c;
                return 1'b1;
            end
            PH_DATA_CR: begin
                if (c != CHAR_CR) return flag_error(res);
                parse_phase = PH_DATA_LF;
                return 1'b0;
            end
            PH_DATA_LF: begin
                if (c != CHAR_LF) return flag_error(res);
                parse_phase = PH_SIZE;
                line_size   = '0;
                size_digits = '0;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] value);
        in_item_t beat;
        beat.action  = ACT_BYTE;
        beat.in_byte = value;
        stim_beats   = {stim_beats, beat};
    endtask

    task automatic push_end();
        in_item_t beat;
        beat.action  = ACT_END;
        beat.in_byte = 8'($urandom);
        stim_beats   = {stim_beats, beat};
    endtask

    task automatic push_crlf();
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
    endtask

    task automatic push_text(input string text);
        for (int i = 0; i < text.len(); i++) push_byte(text[i]);
    endtask

    // hex digit in random case
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 10) return "0" + 8'(nib);
        if ($urandom_range(0, 1)) return "A" + 8'(nib - 4'd10);
        return "a" + 8'(nib - 4'd10);
    endfunction

    // size digits msb first, with optional leading zeros
    task automatic push_size(input logic [63:0] value, input int zeros);
        int          ndig;
        logic [63:0] rest;
        ndig = 1;
        rest = value >> 4;
        while (rest != 0) begin
            ndig++;
            rest = rest >> 4;
        end
        ndig = ndig + zeros;
        if (ndig > MaxSizeDigits) ndig = MaxSizeDigits;
        for (int i = ndig - 1; i >= 0; i--) push_byte(hex_char(value[4*i +: 4]));
    endtask

    // ';' plus skipped bytes; a bare cr is followed by a byte that is neither cr nor lf
    task automatic push_extension();
        logic [7:0] b;
        push_byte(CHAR_SEMI);
        repeat ($urandom_range(0, 5)) begin
            b = 8'($urandom);
            if (b == CHAR_CR) b = "x";
            push_byte(b);
        end
        if ($urandom_range(0, 4) == 0) begin
            push_byte(CHAR_CR);
            push_byte("e");
        end
    endtask

    // one body ending in an end beat: mostly well formed, some broken, some noise
    task automatic build_body(input int max_len);
        int          r;
        int          len;
        int          start;
        int          idx;
        logic [63:0] huge;
        start = stim_beats.size();
        r     = $urandom_range(0, 99);
        if (r < 6) begin
            // noise, random actions included
            repeat ($urandom_range(1, 10)) begin
                if ($urandom_range(0, 3) == 0) push_end();
                else push_byte(8'($urandom));
            end
        end else if (r < 10) begin
            // overlong size line
            push_size({$urandom, $urandom}, MaxSizeDigits);
            push_byte(hex_char(4'($urandom)));
            push_crlf();
        end else begin
            for (int k = $urandom_range(0, 4); k > 0; k--) begin
                if ($urandom_range(0, 99) < 4) begin
                    // 16 digits, top one nonzero: always beyond any limit
                    huge          = {$urandom, $urandom};
                    huge[63:60]   = 4'($urandom_range(1, 15));
                    push_size(huge, 0);
                    push_crlf();
                    break;
                end
                len = $urandom_range(1, max_len);
                push_size(64'(len), $urandom_range(0, 2));
                if ($urandom_range(0, 3) == 0) push_extension();
                push_crlf();
                repeat (len) push_byte(8'($urandom));
                push_crlf();
            end
            push_size(64'd0, $urandom_range(0, 1));
            if ($urandom_range(0, 4) == 0) push_extension();
            push_crlf();
            // trailer, ignored after completion
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
            r = $urandom_range(0, 99);
            if (r < 15 && stim_beats.size() > start) begin
                idx = $urandom_range(start, stim_beats.size() - 1);
                stim_beats[idx].in_byte = 8'($urandom);
            end else if (r < 25 && stim_beats.size() > start + 1) begin
                // cut short before the zero chunk, as a rule
                idx = $urandom_range(start + 1, stim_beats.size() - 1);
                while (stim_beats.size() > idx) void'(stim_beats.pop_back());
            end
        end
        push_end();
    endtask

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // present one beat at the falling edge, returns at the accepting rising edge
    task automatic send_beat(input in_item_t beat);
        out_item_t res;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) begin
            input_stalls++;
            @(posedge aclk);
        end
        sent_beats++;
        if (!(beat.action == ACT_BYTE && (parse_phase == PH_DONE || parse_phase == PH_ERROR)))
            parsed_beats++;
        if (decode_beat(beat, res)) decode_due = {decode_due, res};
    endtask

    // send the queued beats in bursts, with random gaps if tx_gap_max is nonzero, then drop valid
    task automatic play_beats();
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 16);
        foreach (stim_beats[i]) begin
            if (burst_left == 0) begin
                if (tx_gap_max > 0) begin
                    gap = $urandom_range(1, tx_gap_max);
                    @(negedge aclk);
                    s_valid <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
                burst_left = $urandom_range(1, 16);
            end
            send_beat(stim_beats[i]);
            burst_left--;
        end
        stim_beats.delete();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // returns at a rising edge once nothing is owed
    task automatic wait_drained();
        do @(posedge aclk); while (decode_due.size() != 0);
    endtask

    // limit write while idle; beats without a result may still be in flight
    task automatic write_config(input logic [TotalW-1:0] limit);
        wait_drained();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        do @(posedge aclk); while (!cfg_ready);
        body_limit = limit;
        limit_phases++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: long hold-off on request, else always ready at stall_pct 0, else runs of ready/stall
    always @(negedge aclk) begin
        if (hold_off_left > 0) begin
            m_ready <= 1'b0;
            hold_off_left--;
        end else if (stall_pct == 0) begin
            m_ready <= 1'b1;
        end else begin
            if (rx_run_left == 0) begin
                rx_run_level = $urandom_range(0, 99) >= stall_pct;
                rx_run_left  = $urandom_range(1, 8);
            end
            m_ready <= rx_run_level;
            rx_run_left--;
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (decode_due.size() == 0) begin
                $error("result beat with nothing expected: kind %0d byte %02h",
                       m_data.kind, m_data.out_byte);
                fail_count++;
            end else begin
                oldest_due = decode_due.pop_front();
                if (m_data.kind !== oldest_due.kind) begin
                    $error("kind: expected %0d, actual %0d", oldest_due.kind, m_data.kind);
                    fail_count++;
                end
                if (m_data.out_byte !== oldest_due.out_byte) begin
                    $error("out_byte: expected %02h, actual %02h",
                           oldest_due.out_byte, m_data.out_byte);
                    fail_count++;
                end
                case (oldest_due.kind)
                    KIND_DATA: data_seen++;
                    KIND_DONE: done_seen++;
                    default:   error_seen++;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout at cycle %0d, %0d results still owed", cycle_count,
                     decode_due.size());
            $display("** chunked_transfer_decoder: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extension with a bare cr, data extremes, completion, ignored trailer
    task automatic test_well_formed_body();
        push_text("2;");
        push_byte(CHAR_CR);
        push_text("x");
        push_crlf();
        push_byte(8'hFF);
        push_byte(8'h00);
        push_crlf();
        push_text("0");
        push_crlf();
        push_text("Z");
        push_end();
        play_beats();
    endtask

    task automatic test_size_line_faults();
        // empty size, by ';' and by cr; later bytes ignored
        push_text(";A");
        push_end();
        push_byte(CHAR_CR);
        push_end();
        // sixteen digits in mixed case pass, the seventeenth fails
        push_text("FaBcDeF0123456789");
        push_end();
        // bad character, and a cr with no lf behind it
        push_text("1g");
        push_end();
        push_text("1");
        push_byte(CHAR_CR);
        push_text("1");
        push_end();
        // end beats on an open body, twice in a row
        push_end();
        push_end();
        play_beats();
    endtask

    // data not closed by crlf: wrong first byte, then wrong second byte
    task automatic test_data_framing_faults();
        push_text("1");
        push_crlf();
        push_text("qx");
        push_end();
        push_text("1");
        push_crlf();
        push_text("q");
        push_byte(CHAR_CR);
        push_text("x");
        push_end();
        play_beats();
    endtask

    task automatic test_total_limit();
        // body filling a one-byte limit exactly
        write_config(25'd1);
        push_text("1");
        push_crlf();
        push_text("z");
        push_crlf();
        push_text("0");
        push_crlf();
        push_end();
        play_beats();
        // chunk bigger than the room left
        write_config(25'd2);
        push_text("3");
        push_crlf();
        push_end();
        play_beats();
        // limit lowered mid-body below what already went out
        push_text("2");
        push_crlf();
        push_text("ab");
        push_crlf();
        play_beats();
        write_config(25'd1);
        push_text("1");
        push_crlf();
        push_end();
        play_beats();
        write_config(LimitMax);
    endtask

    // receiver holds off while the sender keeps offering, then full drain, then random bodies under stalls
    task automatic test_backpressure();
        wait_drained();
        tx_gap_max    = 0;
        stall_pct     = 0;
        hold_off_left = 200;
        push_size(64'd64, 0);
        push_crlf();
        repeat (64) push_byte(8'($urandom));
        push_crlf();
        push_size(64'd0, 0);
        push_crlf();
        push_end();
        play_beats();
        wait_drained();
        stall_pct = 60;
        repeat (2) build_body(24);
        play_beats();
        wait_drained();
    endtask

    task automatic test_random_bodies();
        logic [TotalW-1:0] limits[6];
        int                start;
        start  = sent_beats;
        limits = '{MAX_TOTAL_RESET, LimitMax, 25'd1,
                   25'($urandom_range(8, 64)), 25'($urandom_range(16, 128)),
                   25'($urandom_range(65, 16777216))};
        for (int p = 0; p < 6; p++) begin
            write_config(limits[p]);
            // first setting runs with no idling on either side
            stall_pct  = (p % 3) * 30;
            tx_gap_max = (p * 2) % 7;
            while (sent_beats < start + (p + 1) * RandomBeats / 6) begin
                build_body(24);
                play_beats();
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_well_formed_body();
        test_size_line_faults();
        test_data_framing_faults();
        test_total_limit();
        test_backpressure();
        test_random_bodies();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (decode_due.size() != 0) begin
            $error("%0d expected results never arrived", decode_due.size());
            fail_count++;
        end
        $display("sent %0d beats (%0d parsed) over %0d limit settings, %0d input stall cycles",
                 sent_beats, parsed_beats, limit_phases, input_stalls);
        $display("checked %0d data bytes, %0d completed bodies, %0d error results",
                 data_seen, done_seen, error_seen);
        if (fail_count == 0) begin
            $display("** chunked_transfer_decoder: PASSED **");
        end else begin
            $display("** chunked_transfer_decoder: FAILED **");
        end
        $finish;
    end

endmodule
